// ----- rtl/ms_pkg.sv -----
// ----------------------------------------------------------------------------
// ms_pkg: shared types for the median selector
// Job descriptor passed from the loader to the selector, and selector states.
// ----------------------------------------------------------------------------
package ms_pkg;

	// Wide enough for a list count of up to 8191 entries.
	localparam int JOB_CNT_W = 13;

	typedef struct packed {
		logic [JOB_CNT_W-1:0] count;
		logic                 dropped;
	} ms_job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CAND,
		ST_CAND_WAIT,
		ST_SCAN,
		ST_DRAIN,
		ST_CHECK,
		ST_FINISH
	} ms_state_t;

endpackage

// ----- rtl/ms_front.sv -----
// ----------------------------------------------------------------------------
// ms_front: list loader
// Writes each beat into the element store while it has room; posts a job on the last beat.
// ----------------------------------------------------------------------------
module ms_front #(
	parameter int MAX_ITEMS = 64,
	parameter int AW = 6,
	parameter int CW = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [31:0]          in_value,
	input  logic                 in_last,
	output logic                 wr_en,
	output logic [AW-1:0]        wr_addr,
	output logic [31:0]          wr_data,
	output logic                 job_push,
	output ms_pkg::ms_job_t      job
);
	import ms_pkg::*;

	logic [CW-1:0] count_q;
	logic          drop_q;
	logic          take;
	logic          room;
	logic [CW-1:0] count_nx;

	assign take     = in_valid & in_ready;
	assign room     = (count_q < CW'(MAX_ITEMS));
	assign count_nx = room ? count_q + CW'(1) : count_q;

	assign wr_en    = take & room;
	assign wr_addr  = count_q[AW-1:0];
	assign wr_data  = in_value;
	assign job_push = take & in_last;
	assign job.count   = JOB_CNT_W'(count_nx);
	assign job.dropped = drop_q | ~room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drop_q  <= 1'b0;
		end else if (take) begin
			if (in_last) begin
				count_q <= '0;
				drop_q  <= 1'b0;
			end else begin
				count_q <= count_nx;
				drop_q  <= drop_q | ~room;
			end
		end
	end

endmodule

// ----- rtl/ms_queue.sv -----
// ----------------------------------------------------------------------------
// ms_queue: two-entry job queue
// Decouples the loader from the selector.
// ----------------------------------------------------------------------------
module ms_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ms_pkg::ms_job_t push_job,
	input  logic            pop,
	output logic            not_empty,
	output ms_pkg::ms_job_t head
);
	import ms_pkg::*;

	ms_job_t     slot_q [2];
	logic        wp_q;
	logic        rp_q;
	logic [1:0]  fill_q;

	assign not_empty = (fill_q != 2'd0);
	assign head      = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && fill_q != 2'd2) begin
			slot_q[wp_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push && fill_q != 2'd2) wp_q <= ~wp_q;
			if (pop && not_empty) rp_q <= ~rp_q;
			fill_q <= fill_q + 2'((push && fill_q != 2'd2) ? 1 : 0)
				- 2'((pop && not_empty) ? 1 : 0);
		end
	end

endmodule

// ----- rtl/ms_back.sv -----
// ----------------------------------------------------------------------------
// ms_back: rank-counting selector
// Holds the element store; ranks each candidate by a full scan of the list.
// ----------------------------------------------------------------------------
module ms_back #(
	parameter int MAX_ITEMS = 64,
	parameter int AW = 6,
	parameter int CW = 7
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  logic [31:0]     wr_data,
	input  logic            job_valid,
	input  ms_pkg::ms_job_t job,
	output logic            job_pop,
	output logic            idle,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [39:0]     m_tdata,
	output logic            m_tuser
);
	import ms_pkg::*;

	logic [31:0]   mem [MAX_ITEMS];
	logic [31:0]   rd_data_q;
	logic [AW-1:0] rd_addr;

	ms_state_t     state_q, state_nx;
	logic [CW-1:0] n_q, i_q, j_q, less_q, eq_q;
	logic          drop_q;
	logic [31:0]   cand_q, hi_q, lo_q;
	logic          hit_v_s1;
	logic          out_valid_q;
	logic [32:0]   out_data_q;
	logic          out_drop_q;

	logic [CW:0]   k, km1, lo_b, hi_b;
	logic          even, hit_k, hit_km1;
	logic [32:0]   sum;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data_q <= mem[rd_addr];
	end

	assign k       = (CW+1)'(n_q >> 1);
	assign km1     = k - (CW+1)'(1);
	assign even    = ~n_q[0];
	assign lo_b    = (CW+1)'(less_q);
	assign hi_b    = (CW+1)'(less_q) + (CW+1)'(eq_q);
	assign hit_k   = (lo_b <= k) && (k < hi_b);
	assign hit_km1 = (lo_b <= km1) && (km1 < hi_b);
	assign sum     = {hi_q[31], hi_q} + (even ? {lo_q[31], lo_q} : {hi_q[31], hi_q});

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:      if (job_valid) state_nx = ST_CAND;
			ST_CAND:      state_nx = ST_CAND_WAIT;
			ST_CAND_WAIT: state_nx = ST_SCAN;
			ST_SCAN:      if (j_q == n_q - CW'(1)) state_nx = ST_DRAIN;
			ST_DRAIN:     state_nx = ST_CHECK;
			ST_CHECK:     state_nx = (i_q == n_q - CW'(1)) ? ST_FINISH : ST_CAND;
			ST_FINISH:    if (!out_valid_q) state_nx = ST_IDLE;
			default:      state_nx = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		idle    = (state_q == ST_IDLE);
		job_pop = (state_q == ST_IDLE) && job_valid;
		rd_addr = (state_q == ST_CAND) ? i_q[AW-1:0] : j_q[AW-1:0];
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_data_q};
	assign m_tuser  = out_drop_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				n_q    <= CW'(job.count);
				drop_q <= job.dropped;
				i_q    <= '0;
			end
			ST_CAND: begin
				less_q <= '0;
				eq_q   <= '0;
				j_q    <= '0;
			end
			ST_CAND_WAIT: cand_q <= rd_data_q;
			ST_SCAN: j_q <= j_q + CW'(1);
			ST_CHECK: begin
				if (hit_k) hi_q <= cand_q;
				if (even && hit_km1) lo_q <= cand_q;
				i_q <= i_q + CW'(1);
			end
			default: ;
		endcase
		if (hit_v_s1) begin
			if ($signed(rd_data_q) < $signed(cand_q)) less_q <= less_q + CW'(1);
			if (rd_data_q == cand_q) eq_q <= eq_q + CW'(1);
		end
		if (state_q == ST_FINISH && !out_valid_q) begin
			out_data_q <= sum;
			out_drop_q <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hit_v_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_nx;
			hit_v_s1 <= (state_q == ST_SCAN);
			if (state_q == ST_FINISH && !out_valid_q) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

`ifndef ASSERT_OFF
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> j_q < n_q)
		else $error("scan index past list end");
	a_compare_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> hit_v_s1)
		else $error("last compare missing in drain");
	a_rank_total: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK |-> hi_b <= (CW+1)'(n_q))
		else $error("rank counts exceed list size");
	a_single_pop: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> !job_pop)
		else $error("job popped twice in a row");
`endif

endmodule

// ----- rtl/median_select.sv -----
// ----------------------------------------------------------------------------
// median_select: median of a streamed list, doubled
// Loads signed 32-bit values, then selects the middle order statistic(s).
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                          | tuser       | tlast
//  s_axis   | in  | [31:0] value (signed)          | -           | last
//  m_axis   | out | [32:0] median_doubled, pad 0   | overflowed  | -
//
// Loading takes one beat per cycle while s_tready is high. After the last
// beat the selector ranks every element by a full scan of the stored list
// through one memory read port, one candidate after another. s_tready is
// held low while a list is queued or being ranked. A result waits in the
// output register until taken; the next list may load meanwhile. arst_n
// clears the FSM state, loader counters, queue pointers and valid flags;
// the element store is never cleared.
// ----------------------------------------------------------------------------
module median_select #(
	parameter int MAX_ITEMS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [32:0] median_doubled, [39:33] zero
	output logic        m_tuser    // [0] overflowed
);
	import ms_pkg::*;

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_data;
	logic          job_push, job_pop, job_valid, back_idle;
	ms_job_t       job_in, job_head;

	// accept only while no list is queued or being ranked
	assign s_tready = ~job_valid & back_idle;

	ms_front #(.MAX_ITEMS(MAX_ITEMS), .AW(AW), .CW(CW)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_value (s_tdata),
		.in_last  (s_tlast),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.job_push (job_push),
		.job      (job_in)
	);

	ms_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_job  (job_in),
		.pop       (job_pop),
		.not_empty (job_valid),
		.head      (job_head)
	);

	ms_back #(.MAX_ITEMS(MAX_ITEMS), .AW(AW), .CW(CW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.job_valid (job_valid),
		.job       (job_head),
		.job_pop   (job_pop),
		.idle      (back_idle),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for median_select
// Streams signed lists into the block and predicts twice the median of each
// list (sum of the two middle values for even counts), plus the overflow flag.
// A queue-fed driver and a clocked monitor run through several idling phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int CAP = 64;

	typedef struct {
		logic [31:0] value;
		logic        last;
	} beat_t;

	typedef struct {
		logic [32:0] median_doubled;
		logic        overflowed;
	} median_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tuser;

	beat_t   pending_beats[$];
	median_t expected_medians[$];

	// predictor state: the list being loaded
	logic signed [31:0] list_vals[CAP];
	int                 list_len;
	logic               list_dropped;

	int errors;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_off;

	median_select #(.MAX_ITEMS(CAP)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Sort a copy of the list and take the middle order statistic(s).
	function automatic median_t median_of_list();
		logic signed [31:0] s[CAP];
		logic signed [31:0] t;
		logic signed [32:0] sum;
		int j;
		median_t r;
		for (int i = 0; i < list_len; i++) s[i] = list_vals[i];
		for (int i = 1; i < list_len; i++) begin
			j = i;
			while (j > 0 && s[j-1] > s[j]) begin
				t = s[j]; s[j] = s[j-1]; s[j-1] = t;
				j--;
			end
		end
		if (list_len % 2 == 0)
			sum = 33'(s[list_len/2 - 1]) + 33'(s[list_len/2]);
		else
			sum = 33'(s[list_len/2]) <<< 1;
		r.median_doubled = sum;
		r.overflowed = list_dropped;
		return r;
	endfunction

	// Model one accepted beat.
	task automatic absorb_beat(input beat_t b);
		if (list_len < CAP) begin
			list_vals[list_len] = b.value;
			list_len++;
		end else begin
			list_dropped = 1'b1;
		end
		if (b.last) begin
			expected_medians.push_back(median_of_list());
			list_len = 0;
			list_dropped = 1'b0;
		end
	endtask

	// Driver: offer queued beats; hold the current one until accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				absorb_beat(beat_t'{s_tdata, s_tlast});
			if (!s_tvalid || s_tready) begin
				if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					beat_t b;
					b = pending_beats.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= b.value;
					s_tlast  <= b.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result beat, then choose the next ready level.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_medians.size() == 0) begin
					report_mismatch("unexpected result", {24'd0, m_tdata}, 64'd0);
				end else begin
					median_t e;
					e = expected_medians.pop_front();
					if (m_tdata[32:0] !== e.median_doubled)
						report_mismatch("median_doubled", 64'(m_tdata[32:0]),
							64'(e.median_doubled));
					if (m_tdata[39:33] !== 7'd0)
						report_mismatch("tdata padding", 64'(m_tdata[39:33]), 64'd0);
					if (m_tuser !== e.overflowed)
						report_mismatch("overflowed", 64'(m_tuser), 64'(e.overflowed));
				end
			end
			m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic logic [31:0] rand_value(input int mode);
		case (mode)
			0: return $urandom_range(20) - 10;
			1: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Queue one list of n elements (value pattern chosen by mode).
	task automatic queue_list(input int n, input int mode);
		for (int i = 0; i < n; i++)
			pending_beats.push_back(beat_t'{rand_value(mode), i == n - 1});
	endtask

	task automatic drain_queue();
		while (pending_beats.size() > 0 || s_tvalid) @(posedge clk);
	endtask

	initial begin
		errors = 0;
		hold_off = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		list_len = 0;
		list_dropped = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: single extremes, even and odd, duplicates, mixed signs
		pending_beats.push_back(beat_t'{32'h7fff_ffff, 1'b1});
		pending_beats.push_back(beat_t'{32'h8000_0000, 1'b1});
		pending_beats.push_back(beat_t'{32'h7fff_ffff, 1'b0});
		pending_beats.push_back(beat_t'{32'h7fff_ffff, 1'b1});
		pending_beats.push_back(beat_t'{32'h8000_0000, 1'b0});
		pending_beats.push_back(beat_t'{32'h8000_0000, 1'b1});
		pending_beats.push_back(beat_t'{32'h8000_0000, 1'b0});
		pending_beats.push_back(beat_t'{32'h7fff_ffff, 1'b1});
		pending_beats.push_back(beat_t'{32'hffff_ffff, 1'b0});
		pending_beats.push_back(beat_t'{32'h0000_0000, 1'b0});
		pending_beats.push_back(beat_t'{32'h0000_0001, 1'b1});
		queue_list(6, 0);
		queue_list(7, 1);
		drain_queue();

		// store full: over capacity, with the dropped beat ending the list
		queue_list(CAP + 3, 2);
		queue_list(CAP, 0);
		queue_list(CAP + 1, 0);
		queue_list(3, 2);
		drain_queue();

		// random lists through the idling phases; mostly short lists
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
				default: begin send_idle_pct = 15; recv_stall_pct = 15; end
			endcase
			for (int c = 0; c < 50; ) begin
				int n;
				n = ($urandom_range(15) == 0) ? $urandom_range(CAP + 4, 40)
					: $urandom_range(12, 1);
				queue_list(n, $urandom_range(2));
				c += n;
			end
			if (phase == 2) begin
				// long receiver hold-off while lists keep arriving
				hold_off = 1'b1;
				repeat (3000) @(posedge clk);
				hold_off = 1'b0;
			end
			drain_queue();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		while (expected_medians.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("median_select test passed");
		else
			$display("median_select test failed");
		$finish;
	end

	initial begin
		#50ms;
		$display("median_select test failed");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/ms_pkg.sv
rtl/ms_front.sv
rtl/ms_queue.sv
rtl/ms_back.sv
rtl/median_select.sv
bench/testbench.sv
